// ===== rtl/swd_host_transfer_engine_defines.svh =====
// Assertion macros used by the top level of the serial-wire-debug host.
`ifndef SWD_HOST_TRANSFER_ENGINE_DEFINES_SVH
`define SWD_HOST_TRANSFER_ENGINE_DEFINES_SVH

// Checks a property on every rising edge of clk while reset is released.
`define SWD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks a plain condition on every rising edge of clk while reset is released.
`define SWD_CHECK(lbl, cond, msg) \
	`SWD_ASSERT(lbl, (1'b1 |-> (cond)), msg)

`endif

// ===== rtl/swd_pkg.sv =====
// Package with the types, codes and helper functions of the serial-wire-debug host.
package swd_pkg;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_REQ      = 5'd1,
		PH_TRN_ACK  = 5'd2,
		PH_ACK      = 5'd3,
		PH_DUMMY    = 5'd4,
		PH_TRN_ERR  = 5'd5,
		PH_AB_REQ   = 5'd6,
		PH_AB_TRN1  = 5'd7,
		PH_AB_ACK   = 5'd8,
		PH_AB_TRN2  = 5'd9,
		PH_AB_DATA  = 5'd10,
		PH_AB_IDLE  = 5'd11,
		PH_RDATA    = 5'd12,
		PH_TRN_DATA = 5'd13,
		PH_WDATA    = 5'd14,
		PH_IDLE_CLK = 5'd15,
		PH_LR1      = 5'd16,
		PH_SEQ      = 5'd17,
		PH_LR2      = 5'd18,
		PH_ZERO     = 5'd19,
		PH_DONE     = 5'd31
	} phase_t;

	localparam logic [2:0] ACT_XFER   = 3'd0;
	localparam logic [2:0] ACT_ABORT  = 3'd1;
	localparam logic [2:0] ACT_LRESET = 3'd2;
	localparam logic [2:0] ACT_JTAG   = 3'd3;
	localparam logic [2:0] ACT_TICK   = 3'd4;

	localparam logic [1:0] K_XFER   = 2'd0;
	localparam logic [1:0] K_ABORT  = 2'd1;
	localparam logic [1:0] K_LRESET = 2'd2;
	localparam logic [1:0] K_JTAG   = 2'd3;

	localparam logic [2:0] ACK_OK    = 3'h1;
	localparam logic [2:0] ACK_WAIT  = 3'h2;
	localparam logic [2:0] ACK_FAULT = 3'h4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_WAIT_TO = 2'd1;
	localparam logic [1:0] ST_FAULT   = 2'd2;
	localparam logic [1:0] ST_PARITY  = 2'd3;

	localparam logic [1:0] CFG_TURNAROUND = 2'd0;
	localparam logic [1:0] CFG_DUMMY_EN   = 2'd1;
	localparam logic [1:0] CFG_IDLE       = 2'd2;
	localparam logic [1:0] CFG_WAIT_LIMIT = 2'd3;

	localparam logic [31:0] STICKY_CLEAR = 32'h0000_001E;
	localparam logic [15:0] SWITCH_SEQ   = 16'hE79E;
	localparam logic [7:0]  DATA_BITS    = 8'd33;
	localparam logic [7:0]  RESET_CLOCKS = 8'd60;
	localparam logic [7:0]  ABORT_HDR    = 8'h81;

	typedef struct packed {
		logic [2:0]  turnaround;
		logic        dummy_en;
		logic [7:0]  idle;
		logic [15:0] wait_limit;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic        swdio_out;
		logic        swdio_oe;
		logic        done;
		logic [2:0]  ack;
		logic [31:0] data;
		logic [1:0]  status;
	} res_t;

	function automatic logic par32(input logic [31:0] v);
		return ^v;
	endfunction

	function automatic logic [7:0] build_request(input logic ap, input logic rd,
			input logic [1:0] addr);
		return {1'b1, 1'b0, ap ^ rd ^ addr[0] ^ addr[1], addr[1], addr[0], rd, ap, 1'b1};
	endfunction

	function automatic logic [7:0] seg_len(input phase_t p, input cfg_t cfg);
		logic [7:0] len;
		len = 8'd1;
		case (p)
			PH_REQ, PH_AB_REQ, PH_ZERO: len = 8'd8;
			PH_ACK, PH_AB_ACK: len = 8'd3;
			PH_DUMMY, PH_AB_DATA, PH_RDATA, PH_WDATA: len = DATA_BITS;
			PH_TRN_ERR: len = {5'd0, cfg.turnaround};
			PH_AB_IDLE, PH_IDLE_CLK: len = cfg.idle;
			PH_LR1, PH_LR2: len = RESET_CLOCKS;
			PH_SEQ: len = 8'd16;
			default: len = 8'd1;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/swd_host_transfer_engine.sv =====
// Top level of the serial-wire-debug host: handshakes, configuration and result register.
// Each accepted beat is handled as it is accepted; a clock-tick beat's result appears in the
// output register on the next cycle, and throughput is one beat a clock while no result waits.
// Command beats give no result; the whole per-period step sits between the sequencer
// state registers and the output register, and input stalls only while a result waits.
// Reset clears the sequencer to idle with SWDIO held high and loads the register defaults.
module swd_host_transfer_engine import swd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic        ap,
	input  logic        read,
	input  logic [1:0]  reg_addr,
	input  logic [31:0] wr_word,
	input  logic        swdio_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        swdio_out,
	output logic        swdio_oe,
	output logic        done_res,
	output logic [2:0]  ack,
	output logic [31:0] data_word,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

`include "swd_host_transfer_engine_defines.svh"

	cfg_t cfg_q;
	res_t res;
	logic accept;
	logic out_valid_q;
	logic swdio_out_q;
	logic swdio_oe_q;
	logic done_res_q;
	logic [2:0] ack_q;
	logic [31:0] data_q;
	logic [1:0] status_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	swd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.ap          (ap),
		.read        (read),
		.reg_addr    (reg_addr),
		.wr_word     (wr_word),
		.swdio_in    (swdio_in),
		.cfg         (cfg_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{turnaround: 3'd1, dummy_en: 1'b0, idle: 8'd8, wait_limit: 16'd100};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TURNAROUND: cfg_q.turnaround <= cfg_data[2:0];
				CFG_DUMMY_EN:   cfg_q.dummy_en <= cfg_data[0];
				CFG_IDLE:       cfg_q.idle <= cfg_data[7:0];
				CFG_WAIT_LIMIT: cfg_q.wait_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			swdio_out_q <= res.swdio_out;
			swdio_oe_q <= res.swdio_oe;
			done_res_q <= res.done;
			ack_q <= res.ack;
			data_q <= res.data;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign swdio_out = swdio_out_q;
	assign swdio_oe = swdio_oe_q;
	assign done_res = done_res_q;
	assign ack = ack_q;
	assign data_word = data_q;
	assign status = status_q;

	`SWD_CHECK(a_ready_when_empty, (!out_valid_q -> in_ready), "Input stalled while empty.")
	`SWD_ASSERT(a_command_no_result, (accept && action != ACT_TICK) |=> !out_valid_q, "Command gave a result.")
	`SWD_ASSERT(a_mid_quiet, (out_valid_q && !done_res_q) |-> (status_q == ST_OK && data_q == '0), "Early status.")

endmodule

// ===== rtl/swd_core.sv =====
// Sequencer state and per-period logic of the serial-wire-debug host.
module swd_core import swd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [2:0]  action,
	input  logic        ap,
	input  logic        read,
	input  logic [1:0]  reg_addr,
	input  logic [31:0] wr_word,
	input  logic        swdio_in,
	input  cfg_t        cfg,
	output res_t        res
);

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  bit_idx;
		logic [31:0] data_shift;
		logic [7:0]  request_byte;
		logic [2:0]  ack_reg;
		logic [15:0] retry_cnt;
		logic        fault_used;
		logic        drive_level;
		logic [1:0]  cmd_kind;
		logic        rx_parity;
	} seq_t;

	typedef struct packed {
		seq_t        st;
		phase_t      nxt;
		logic [1:0]  status;
		logic [31:0] data;
	} step_t;

	seq_t st_q;
	seq_t st_d;

	function automatic step_t step(input step_t si, input cfg_t c);
		step_t so;
		logic  rd;
		so = si;
		rd = si.st.request_byte[2];
		case (si.nxt)
			PH_REQ: so.nxt = PH_TRN_ACK;
			PH_TRN_ACK: so.nxt = PH_ACK;
			PH_ACK: begin
				if (si.st.cmd_kind == K_ABORT) begin
					so.nxt = (si.st.ack_reg == ACK_OK || si.st.ack_reg == ACK_FAULT) ?
						PH_TRN_DATA : PH_TRN_ERR;
				end else if (si.st.ack_reg == ACK_OK) begin
					if (rd) begin
						so.st.data_shift = '0;
						so.nxt = PH_RDATA;
					end else begin
						so.nxt = PH_TRN_DATA;
					end
				end else begin
					so.nxt = c.dummy_en ? PH_DUMMY : PH_TRN_ERR;
				end
			end
			PH_DUMMY: so.nxt = PH_TRN_ERR;
			PH_TRN_ERR: begin
				so.st.drive_level = 1'b1;
				if (si.st.cmd_kind == K_ABORT) begin
					if (si.st.ack_reg != ACK_WAIT || si.st.retry_cnt == '0) begin
						so.nxt = PH_TRN_DATA;
					end else begin
						so.st.retry_cnt = si.st.retry_cnt - 16'd1;
						so.nxt = PH_REQ;
					end
				end else if (si.st.ack_reg == ACK_FAULT && !si.st.fault_used) begin
					so.st.fault_used = 1'b1;
					so.nxt = PH_AB_REQ;
				end else if (si.st.ack_reg != ACK_WAIT || si.st.retry_cnt == '0) begin
					so.status = (si.st.ack_reg == ACK_WAIT) ? ST_WAIT_TO : ST_FAULT;
					so.data = '0;
					so.nxt = PH_DONE;
				end else begin
					so.st.retry_cnt = si.st.retry_cnt - 16'd1;
					so.nxt = PH_REQ;
				end
			end
			PH_AB_REQ: so.nxt = PH_AB_TRN1;
			PH_AB_TRN1: so.nxt = PH_AB_ACK;
			PH_AB_ACK: so.nxt = PH_AB_TRN2;
			PH_AB_TRN2: so.nxt = PH_AB_DATA;
			PH_AB_DATA: so.nxt = PH_AB_IDLE;
			PH_AB_IDLE: begin
				so.st.drive_level = 1'b1;
				so.nxt = PH_REQ;
			end
			PH_RDATA: so.nxt = PH_TRN_DATA;
			PH_TRN_DATA: so.nxt = rd ? PH_IDLE_CLK : PH_WDATA;
			PH_WDATA: so.nxt = PH_IDLE_CLK;
			PH_IDLE_CLK: begin
				so.st.drive_level = 1'b1;
				so.data = si.st.data_shift;
				if (si.st.cmd_kind == K_ABORT) begin
					so.status = (si.st.ack_reg == ACK_OK) ? ST_OK : ST_FAULT;
				end else if (rd) begin
					so.status = (si.st.rx_parity != par32(si.st.data_shift)) ?
						ST_PARITY : ST_OK;
				end else begin
					so.status = ST_OK;
				end
				so.nxt = PH_DONE;
			end
			PH_LR1: begin
				if (si.st.cmd_kind == K_JTAG) begin
					so.nxt = PH_SEQ;
				end else begin
					so.status = ST_OK;
					so.data = '0;
					so.nxt = PH_DONE;
				end
			end
			PH_SEQ: so.nxt = PH_LR2;
			PH_LR2: so.nxt = PH_ZERO;
			default: begin
				so.status = ST_OK;
				so.data = '0;
				so.nxt = PH_DONE;
			end
		endcase
		return so;
	endfunction

	always_comb begin
		logic [7:0] b;
		logic [7:0] bc;
		logic       oe;
		logic       lvl;
		step_t      sp;
		st_d = st_q;
		b = st_q.bit_idx;
		bc = st_q.bit_idx + 8'd1;
		oe = 1'b0;
		lvl = st_q.drive_level;
		sp = '0;
		res = '0;
		if (accept && action <= ACT_JTAG) begin
			if (st_q.phase == PH_IDLE) begin
				st_d.cmd_kind = action[1:0];
				st_d.bit_idx = '0;
				st_d.ack_reg = '0;
				st_d.retry_cnt = cfg.wait_limit;
				st_d.fault_used = 1'b0;
				st_d.rx_parity = 1'b0;
				if (action == ACT_XFER || action == ACT_ABORT) begin
					st_d.request_byte = (action == ACT_XFER) ?
						build_request(ap, read, reg_addr) : ABORT_HDR;
					st_d.data_shift = wr_word;
					st_d.phase = PH_REQ;
				end else begin
					st_d.phase = PH_LR1;
				end
			end
		end else if (accept && action == ACT_TICK) begin
			res.valid = 1'b1;
			if (st_q.phase == PH_IDLE) begin
				oe = 1'b1;
			end else begin
				case (st_q.phase)
					PH_REQ: begin
						oe = 1'b1;
						lvl = st_q.request_byte[b[2:0]];
					end
					PH_AB_REQ: begin
						oe = 1'b1;
						lvl = ABORT_HDR[b[2:0]];
					end
					PH_AB_DATA: begin
						oe = 1'b1;
						lvl = (b < 8'd32) ? STICKY_CLEAR[b[4:0]] : par32(STICKY_CLEAR);
					end
					PH_WDATA: begin
						oe = 1'b1;
						lvl = (b < 8'd32) ? st_q.data_shift[b[4:0]] : par32(st_q.data_shift);
					end
					PH_AB_IDLE, PH_IDLE_CLK, PH_ZERO: begin
						oe = 1'b1;
						lvl = 1'b0;
					end
					PH_LR1, PH_LR2: begin
						oe = 1'b1;
						lvl = 1'b1;
					end
					PH_SEQ: begin
						oe = 1'b1;
						lvl = SWITCH_SEQ[b[3:0]];
					end
					PH_ACK: begin
						if (b == '0) begin
							st_d.ack_reg = {2'b00, swdio_in};
						end else begin
							st_d.ack_reg = st_q.ack_reg | (3'({swdio_in}) << b[1:0]);
						end
					end
					PH_RDATA: begin
						if (b < 8'd32) begin
							st_d.data_shift = st_q.data_shift | (32'({swdio_in}) << b[4:0]);
						end else begin
							st_d.rx_parity = swdio_in;
						end
					end
					default: ;
				endcase
				if (oe) begin
					st_d.drive_level = lvl;
				end
				st_d.bit_idx = bc;
				if (bc >= seg_len(st_q.phase, cfg)) begin
					sp.st = st_d;
					sp.nxt = st_q.phase;
					sp = step(sp, cfg);
					if (sp.nxt != PH_DONE && seg_len(sp.nxt, cfg) == '0) begin
						sp = step(sp, cfg);
					end
					st_d = sp.st;
					st_d.bit_idx = '0;
					if (sp.nxt == PH_DONE) begin
						st_d.phase = PH_IDLE;
						res.done = 1'b1;
						res.data = sp.data;
						res.status = sp.status;
					end else begin
						st_d.phase = sp.nxt;
					end
				end
			end
			res.swdio_out = lvl;
			res.swdio_oe = oe;
			res.ack = st_d.ack_reg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, drive_level: 1'b1, default: '0};
		end else begin
			st_q <= st_d;
		end
	end

endmodule

// ===== tb/sv/swd_host_transfer_engine_test.sv =====
// Self-checking testbench for the serial-wire-debug host transfer engine.
`timescale 1ns / 1ps

module swd_host_transfer_engine_test;
	import swd_pkg::*;

	localparam int LIMIT = 400000;

	typedef struct packed {
		logic [2:0]  action;
		logic        ap;
		logic        read;
		logic [1:0]  reg_addr;
		logic [31:0] wr_word;
		logic        swdio_in;
	} swd_item_t;

	localparam int ITEM_W = $bits(swd_item_t);

	typedef struct packed {
		logic        lvl;
		logic        oe;
		logic        done;
		logic [2:0]  ack;
		logic [31:0] data;
		logic [1:0]  status;
	} swd_beat_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  action;
	logic        ap;
	logic        read;
	logic [1:0]  reg_addr;
	logic [31:0] wr_word;
	logic        swdio_in;
	logic        out_valid;
	logic        out_ready;
	logic        swdio_out;
	logic        swdio_oe;
	logic        done_res;
	logic [2:0]  ack;
	logic [31:0] data_word;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	swd_host_transfer_engine DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .ap(ap), .read(read), .reg_addr(reg_addr),
		.wr_word(wr_word), .swdio_in(swdio_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.swdio_out(swdio_out), .swdio_oe(swdio_oe), .done_res(done_res),
		.ack(ack), .data_word(data_word), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the sequencer and its registers.
	logic [2:0]  m_turn;
	logic        m_dphase;
	logic [7:0]  m_idle;
	logic [15:0] m_wretry;
	phase_t      ph;
	logic [7:0]  bcnt;
	logic [31:0] dshift;
	logic [7:0]  reqb;
	logic [2:0]  ackr;
	logic [15:0] retries;
	logic        fault_used;
	logic        drv;
	logic [1:0]  kind;
	logic        rxpar;
	logic [1:0]  rstat;
	logic [31:0] rdata;

	swd_beat_t   beats_q[$];
	bit          in_took;
	bit          cfg_took;
	int          errors;
	int          cycles;
	int          items_sent;
	int          burst_left;
	int          force_ack;
	bit          force_bad_par;
	logic [2:0]  cur_ack;
	int          n_ticks;
	int          n_done;
	int          n_status[4];
	int          rd_cnt;
	logic [15:0] stall_pat;
	bit          no_stall;

	function automatic logic [7:0] req_byte(input logic a, input logic r, input logic [1:0] ad);
		return {1'b1, 1'b0, a ^ r ^ ad[0] ^ ad[1], ad[1], ad[0], r, a, 1'b1};
	endfunction

	function automatic swd_item_t rand_item();
		return ITEM_W'({$urandom, $urandom});
	endfunction

	function automatic logic [7:0] seg_length(input phase_t p);
		case (p)
			PH_REQ, PH_AB_REQ, PH_ZERO: return 8'd8;
			PH_ACK, PH_AB_ACK: return 8'd3;
			PH_DUMMY, PH_AB_DATA, PH_RDATA, PH_WDATA: return 8'd33;
			PH_TRN_ERR: return {5'd0, m_turn};
			PH_AB_IDLE, PH_IDLE_CLK: return m_idle;
			PH_LR1, PH_LR2: return 8'd60;
			PH_SEQ: return 8'd16;
			default: return 8'd1;
		endcase
	endfunction

	function automatic phase_t advance(input phase_t p);
		case (p)
			PH_REQ: return PH_TRN_ACK;
			PH_TRN_ACK: return PH_ACK;
			PH_ACK: begin
				if (kind == K_ABORT)
					return (ackr == ACK_OK || ackr == ACK_FAULT) ? PH_TRN_DATA : PH_TRN_ERR;
				if (ackr == ACK_OK) begin
					if (reqb[2]) begin
						dshift = '0;
						return PH_RDATA;
					end
					return PH_TRN_DATA;
				end
				return m_dphase ? PH_DUMMY : PH_TRN_ERR;
			end
			PH_DUMMY: return PH_TRN_ERR;
			PH_TRN_ERR: begin
				drv = 1'b1;
				if (kind == K_ABORT) begin
					if (ackr != ACK_WAIT || retries == 0) return PH_TRN_DATA;
					retries--;
					return PH_REQ;
				end
				if (ackr == ACK_FAULT && !fault_used) begin
					fault_used = 1'b1;
					return PH_AB_REQ;
				end
				if (ackr != ACK_WAIT || retries == 0) begin
					rstat = (ackr == ACK_WAIT) ? ST_WAIT_TO : ST_FAULT;
					rdata = '0;
					return PH_DONE;
				end
				retries--;
				return PH_REQ;
			end
			PH_AB_REQ: return PH_AB_TRN1;
			PH_AB_TRN1: return PH_AB_ACK;
			PH_AB_ACK: return PH_AB_TRN2;
			PH_AB_TRN2: return PH_AB_DATA;
			PH_AB_DATA: return PH_AB_IDLE;
			PH_AB_IDLE: begin
				drv = 1'b1;
				return PH_REQ;
			end
			PH_RDATA: return PH_TRN_DATA;
			PH_TRN_DATA: return reqb[2] ? PH_IDLE_CLK : PH_WDATA;
			PH_WDATA: return PH_IDLE_CLK;
			PH_IDLE_CLK: begin
				drv = 1'b1;
				rdata = dshift;
				if (kind == K_ABORT)
					rstat = (ackr == ACK_OK) ? ST_OK : ST_FAULT;
				else if (reqb[2])
					rstat = (rxpar != ^dshift) ? ST_PARITY : ST_OK;
				else
					rstat = ST_OK;
				return PH_DONE;
			end
			PH_LR1: begin
				if (kind == K_JTAG) return PH_SEQ;
				rstat = ST_OK;
				rdata = '0;
				return PH_DONE;
			end
			PH_SEQ: return PH_LR2;
			PH_LR2: return PH_ZERO;
			default: begin
				rstat = ST_OK;
				rdata = '0;
				return PH_DONE;
			end
		endcase
	endfunction

	function automatic bit period_step(input swd_item_t it, output swd_beat_t r);
		logic       lvl;
		logic       oe;
		logic       done;
		logic [7:0] b;
		phase_t     nx;
		r = '0;
		if (it.action <= ACT_JTAG) begin
			if (ph != PH_IDLE) return 0;
			kind = it.action[1:0];
			bcnt = '0;
			ackr = '0;
			retries = m_wretry;
			fault_used = 1'b0;
			rxpar = 1'b0;
			if (it.action == ACT_XFER || it.action == ACT_ABORT) begin
				reqb = (it.action == ACT_XFER) ? req_byte(it.ap, it.read, it.reg_addr)
					: req_byte(1'b0, 1'b0, 2'd0);
				dshift = it.wr_word;
				ph = PH_REQ;
			end else begin
				ph = PH_LR1;
			end
			return 0;
		end
		if (it.action != ACT_TICK) return 0;
		rstat = ST_OK;
		rdata = '0;
		oe = 1'b0;
		lvl = drv;
		done = 1'b0;
		if (ph == PH_IDLE) begin
			oe = 1'b1;
		end else begin
			b = bcnt;
			case (ph)
				PH_REQ: begin oe = 1'b1; lvl = reqb[b[2:0]]; end
				PH_AB_REQ: begin oe = 1'b1; lvl = ABORT_HDR[b[2:0]]; end
				PH_AB_DATA: begin
					oe = 1'b1;
					lvl = (b < 32) ? STICKY_CLEAR[b[4:0]] : ^STICKY_CLEAR;
				end
				PH_WDATA: begin
					oe = 1'b1;
					lvl = (b < 32) ? dshift[b[4:0]] : ^dshift;
				end
				PH_AB_IDLE, PH_IDLE_CLK, PH_ZERO: begin oe = 1'b1; lvl = 1'b0; end
				PH_LR1, PH_LR2: begin oe = 1'b1; lvl = 1'b1; end
				PH_SEQ: begin oe = 1'b1; lvl = SWITCH_SEQ[b[3:0]]; end
				PH_ACK: begin
					if (b == 0) ackr = {2'b00, it.swdio_in};
					else ackr = ackr | (3'(it.swdio_in) << b[1:0]);
				end
				PH_RDATA: begin
					if (b < 32) dshift = dshift | (32'(it.swdio_in) << b[4:0]);
					else rxpar = it.swdio_in;
				end
				default: ;
			endcase
			if (oe) drv = lvl;
			bcnt++;
			if (bcnt >= seg_length(ph)) begin
				nx = advance(ph);
				while (nx != PH_DONE && seg_length(nx) == 0) nx = advance(nx);
				if (nx == PH_DONE) begin
					ph = PH_IDLE;
					done = 1'b1;
				end else begin
					ph = nx;
				end
				bcnt = '0;
			end
		end
		r.lvl = lvl;
		r.oe = oe;
		r.done = done;
		r.ack = ackr;
		r.data = done ? rdata : '0;
		r.status = done ? rstat : ST_OK;
		return 1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		swd_item_t it;
		swd_beat_t r;
		swd_beat_t e;
		cycles++;
		if (cycles > LIMIT) begin
			$display("swd_host_transfer_engine test failed");
			$finish;
		end
		in_took = arst_n && in_valid && in_ready;
		cfg_took = arst_n && cfg_valid && cfg_ready;
		if (arst_n && out_valid && out_ready) begin
			if (beats_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("Unexpected result beat at cycle %0d", cycles);
			end else begin
				e = beats_q.pop_front();
				r = '{swdio_out, swdio_oe, done_res, ack, data_word, status};
				if (r !== e) begin
					errors++;
					if (errors <= 10) begin
						$display("Mismatch at cycle %0d: expected lvl %b oe %b done %b %s",
							cycles, e.lvl, e.oe, e.done, "ack, data and status follow");
						$display("  expected ack %h data %h st %0d, got lvl %b oe %b done %b",
							e.ack, e.data, e.status, r.lvl, r.oe, r.done);
						$display("  got ack %h data %h st %0d", r.ack, r.data, r.status);
					end
				end
			end
		end
		if (cfg_took) begin
			case (cfg_index)
				CFG_TURNAROUND: m_turn = cfg_data[2:0];
				CFG_DUMMY_EN: m_dphase = cfg_data[0];
				CFG_IDLE: m_idle = cfg_data[7:0];
				default: m_wretry = cfg_data[15:0];
			endcase
		end
		if (in_took) begin
			it = '{action, ap, read, reg_addr, wr_word, swdio_in};
			if (period_step(it, r)) begin
				beats_q.push_back(r);
				n_ticks++;
				if (r.done) begin
					n_done++;
					n_status[r.status]++;
				end
			end
		end
	end

	always @(negedge clk) begin
		rd_cnt++;
		if (rd_cnt % 64 == 0) begin
			stall_pat = 16'($urandom);
			no_stall = ($urandom_range(0, 3) == 0);
		end
		out_ready <= no_stall ? 1'b1 : stall_pat[rd_cnt % 16];
	end

	task automatic send_item(input swd_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		{action, ap, read, reg_addr, wr_word, swdio_in} <= it;
		in_valid <= 1'b1;
		items_sent++;
		do @(negedge clk); while (!in_took);
	endtask

	function automatic logic pick_sdio();
		int r;
		if (ph == PH_ACK) begin
			if (bcnt == 0) begin
				r = $urandom_range(0, 99);
				if (force_ack >= 0) cur_ack = force_ack[2:0];
				else if (r < 65) cur_ack = ACK_OK;
				else if (r < 80) cur_ack = ACK_WAIT;
				else if (r < 92) cur_ack = ACK_FAULT;
				else cur_ack = 3'($urandom);
			end
			return cur_ack[bcnt[1:0]];
		end
		if (ph == PH_RDATA && bcnt == 32)
			return (force_bad_par || $urandom_range(0, 9) == 0) ? ~^dshift : ^dshift;
		return 1'($urandom);
	endfunction

	task automatic send_tick();
		swd_item_t it;
		it = rand_item();
		it.action = ACT_TICK;
		it.swdio_in = pick_sdio();
		send_item(it);
	endtask

	task automatic run_cmd(input logic [2:0] act, input bit noise);
		swd_item_t it;
		it = rand_item();
		it.action = act;
		send_item(it);
		while (ph != PH_IDLE) begin
			if (noise && $urandom_range(0, 30) == 0) begin
				it = rand_item();
				it.action = 3'($urandom_range(0, 7));
				if (it.action == ACT_TICK) it.swdio_in = pick_sdio();
				send_item(it);
			end else begin
				send_tick();
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (beats_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic setup(input int t, input int dp, input int idl, input int wr);
		drain();
		write_reg(CFG_TURNAROUND, t);
		write_reg(CFG_DUMMY_EN, dp);
		write_reg(CFG_IDLE, idl);
		write_reg(CFG_WAIT_LIMIT, wr);
	endtask

	task automatic test_idle_and_ignored();
		swd_item_t it;
		send_tick();
		send_tick();
		for (int a = 5; a <= 7; a++) begin
			it = rand_item();
			it.action = 3'(a);
			send_item(it);
		end
	endtask

	task automatic test_transfers();
		force_ack = ACK_OK;
		force_bad_par = 0;
		repeat (2) run_cmd(ACT_XFER, 0);
		force_bad_par = 1;
		run_cmd(ACT_XFER, 1);
		force_bad_par = 0;
		force_ack = 7;
		run_cmd(ACT_XFER, 0);
		force_ack = -1;
	endtask

	task automatic test_wait_and_fault();
		setup(2, 1, 1, 2);
		force_ack = ACK_WAIT;
		run_cmd(ACT_XFER, 0);
		run_cmd(ACT_ABORT, 0);
		force_ack = ACK_FAULT;
		run_cmd(ACT_XFER, 0);
		run_cmd(ACT_ABORT, 0);
		force_ack = ACK_OK;
		run_cmd(ACT_ABORT, 0);
		force_ack = -1;
	endtask

	task automatic test_line_sequences();
		run_cmd(ACT_LRESET, 0);
		run_cmd(ACT_JTAG, 1);
	endtask

	task automatic test_extremes();
		setup(0, 0, 0, 0);
		repeat (2) run_cmd(ACT_XFER, 1);
		setup(7, 1, 3, 1);
		repeat (2) run_cmd(ACT_XFER, 1);
		setup(4, 1, 255, 65535);
		run_cmd(ACT_XFER, 0);
		setup(1, 0, 8, 100);
	endtask

	task automatic test_random();
		int r;
		int since_cfg;
		since_cfg = 0;
		while (items_sent < 1100) begin
			if (since_cfg > 25) begin
				setup($urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 12),
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) : 100);
				since_cfg = 0;
			end
			r = $urandom_range(0, 99);
			if (r < 72) run_cmd(ACT_XFER, 1);
			else if (r < 84) run_cmd(ACT_ABORT, 1);
			else if (r < 90) run_cmd(ACT_LRESET, 1);
			else if (r < 93) run_cmd(ACT_JTAG, 1);
			else test_idle_and_ignored();
			since_cfg++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_TICK;
		ap = 1'b0;
		read = 1'b0;
		reg_addr = '0;
		wr_word = '0;
		swdio_in = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_turn = 3'd1;
		m_dphase = 1'b0;
		m_idle = 8'd8;
		m_wretry = 16'd100;
		ph = PH_IDLE;
		bcnt = '0;
		dshift = '0;
		reqb = '0;
		ackr = '0;
		retries = '0;
		fault_used = 1'b0;
		drv = 1'b1;
		kind = K_XFER;
		rxpar = 1'b0;
		rstat = ST_OK;
		rdata = '0;
		force_ack = -1;
		force_bad_par = 0;
		stall_pat = 16'hA5C3;
		no_stall = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_idle_and_ignored();
		test_transfers();
		test_line_sequences();
		test_wait_and_fault();
		test_extremes();
		test_random();
		drain();
		repeat (10) @(negedge clk);
		$display("Covered %0d input beats giving %0d result beats and %0d finished commands.",
			items_sent, n_ticks, n_done);
		$display("Command status: ok %0d, wait timeout %0d, fault %0d, parity %0d; errors %0d.",
			n_status[0], n_status[1], n_status[2], n_status[3], errors);
		if (errors == 0)
			$display("swd_host_transfer_engine test passed");
		else
			$display("swd_host_transfer_engine test failed");
		$finish;
	end

endmodule

// ===== swd_host_transfer_engine.f =====
+incdir+rtl
rtl/swd_pkg.sv
rtl/swd_core.sv
rtl/swd_host_transfer_engine.sv
tb/sv/swd_host_transfer_engine_test.sv
